// ===== hdl/glsc_pkg.sv =====
// Package for the grid line segment collision check unit.
// Holds grid sizes, coordinate widths, item and register codes, and the walk interface types.
// No dependencies.
`default_nettype none

package glsc_pkg;

	localparam int CELL_W  = 8;
	localparam int GRID_X  = 1 << CELL_W;
	localparam int GRID_Y  = 1 << CELL_W;
	localparam int FRAC_W  = 4;
	localparam int COORD_W = CELL_W + FRAC_W + 1;
	localparam int SIZE_W  = CELL_W + 1;
	localparam int POS_W   = CELL_W + 2;
	localparam int ERR_W   = CELL_W + 4;

	localparam logic [SIZE_W-1:0] SIZE_MAX = SIZE_W'(GRID_X);

	localparam logic ACT_WRITE = 1'b0;
	localparam logic ACT_CHECK = 1'b1;

	localparam logic REG_GRID_WIDTH  = 1'b0;
	localparam logic REG_GRID_HEIGHT = 1'b1;

	typedef struct packed {
		logic load;
		logic adv;
	} walk_ctl_t;

	typedef struct packed {
		logic [CELL_W-1:0] x;
		logic [CELL_W-1:0] y;
		logic              last;
	} walk_sts_t;

endpackage

`default_nettype wire

// ===== hdl/glsc_walk.sv =====
// Bresenham stepper: octant selection, mirroring and error term for one segment.
// Loads the two end cells, then yields one cell per advance.
// Depends on glsc_pkg.
`default_nettype none

module glsc_walk (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire glsc_pkg::walk_ctl_t       ctl,
	input  wire logic [glsc_pkg::CELL_W-1:0] ax,
	input  wire logic [glsc_pkg::CELL_W-1:0] ay,
	input  wire logic [glsc_pkg::CELL_W-1:0] bx,
	input  wire logic [glsc_pkg::CELL_W-1:0] by,
	output glsc_pkg::walk_sts_t            sts
);

	logic signed [glsc_pkg::POS_W-1:0] ax_s, ay_s, bx_s, by_s;
	logic signed [glsc_pkg::POS_W-1:0] ddx, ddy, adx, ady;
	logic signed [glsc_pkg::POS_W-1:0] u1, u2, va, vb, v1, v2, du, dv;
	logic signed [glsc_pkg::ERR_W-1:0] du_e, dv_e, e0, ie, ine;
	logic along_y, mirror, step_neg;

	logic signed [glsc_pkg::POS_W-1:0] u_q, v_q, u2_q, u_nx, v_nx, vv;
	logic signed [glsc_pkg::ERR_W-1:0] err_q, inc_e_q, inc_ne_q;
	logic step_neg_q, along_y_q, mirror_q, diag;

	always_comb begin
		ax_s = $signed({2'b00, ax});
		ay_s = $signed({2'b00, ay});
		bx_s = $signed({2'b00, bx});
		by_s = $signed({2'b00, by});
		ddx = bx_s - ax_s;
		ddy = by_s - ay_s;
		adx = ddx[glsc_pkg::POS_W-1] ? -ddx : ddx;
		ady = ddy[glsc_pkg::POS_W-1] ? -ddy : ddy;
		along_y = ady > adx;
		mirror = (ddx < 0 && ddy > 0) || (ddx > 0 && ddy < 0);
		u1 = along_y ? ay_s : ax_s;
		u2 = along_y ? by_s : bx_s;
		va = along_y ? ax_s : ay_s;
		vb = along_y ? bx_s : by_s;
		v1 = mirror ? -va : va;
		v2 = mirror ? -vb : vb;
		step_neg = !(u2 > u1);
		du = u2 - u1;
		dv = v2 - v1;
		du_e = glsc_pkg::ERR_W'(du);
		dv_e = glsc_pkg::ERR_W'(dv);
		e0 = dv_e + dv_e - du_e;
		ie = dv_e + dv_e;
		ine = ie - du_e - du_e;
	end

	always_comb begin
		diag = step_neg_q ? (err_q > 0) : (err_q >= 0);
		u_nx = step_neg_q ? u_q - 2'sd1 : u_q + 2'sd1;
		if (diag) begin
			v_nx = step_neg_q ? v_q - 2'sd1 : v_q + 2'sd1;
		end else begin
			v_nx = v_q;
		end
		vv = mirror_q ? -v_q : v_q;
		sts.x = along_y_q ? vv[glsc_pkg::CELL_W-1:0] : u_q[glsc_pkg::CELL_W-1:0];
		sts.y = along_y_q ? u_q[glsc_pkg::CELL_W-1:0] : vv[glsc_pkg::CELL_W-1:0];
		sts.last = (u_q == u2_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			u_q <= '0;
			v_q <= '0;
			u2_q <= '0;
			err_q <= '0;
			inc_e_q <= '0;
			inc_ne_q <= '0;
			step_neg_q <= 1'b0;
			along_y_q <= 1'b0;
			mirror_q <= 1'b0;
		end else if (ctl.load) begin
			u_q <= u1;
			v_q <= v1;
			u2_q <= u2;
			err_q <= step_neg ? -e0 : e0;
			inc_e_q <= step_neg ? -ie : ie;
			inc_ne_q <= step_neg ? -ine : ine;
			step_neg_q <= step_neg;
			along_y_q <= along_y;
			mirror_q <= mirror;
		end else if (ctl.adv) begin
			u_q <= u_nx;
			v_q <= v_nx;
			err_q <= diag ? err_q + inc_ne_q : err_q + inc_e_q;
		end
	end

endmodule

`default_nettype wire

// ===== hdl/grid_line_segment_collision_check_unit.sv =====
// Top level of the grid line segment collision check unit: occupancy memory and sequencer.
// Depends on glsc_pkg and glsc_walk.
//
// The occupancy grid is a 256 by 256 bit memory, one 256-bit row per y, with a registered
// read. After reset the unit clears the memory one row a cycle and accepts no item until
// then; configuration writes are taken at any time. Items are handled one at a time. A
// write item reads its row, merges the bit and writes it back before the next beat is
// accepted. A check item first tests the endpoints and loads the stepper, then reads the
// memory once per visited cell, then checks the last row and posts the result. A segment
// with an endpoint outside the grid skips the walk and is reported as not free. The result
// sits in an output register, so a new item is accepted while the previous result waits.
`default_nettype none

module grid_line_segment_collision_check_unit (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 cfg_we,
	input  wire logic                                 cfg_index,
	input  wire logic [glsc_pkg::SIZE_W-1:0]          cfg_data,
	input  wire logic                                 in_valid,
	output logic                                      in_ready,
	input  wire logic                                 action,
	input  wire logic [glsc_pkg::CELL_W-1:0]          cell_x,
	input  wire logic [glsc_pkg::CELL_W-1:0]          cell_y,
	input  wire logic                                 cell_occupied,
	input  wire logic signed [glsc_pkg::COORD_W-1:0]  start_x,
	input  wire logic signed [glsc_pkg::COORD_W-1:0]  start_y,
	input  wire logic signed [glsc_pkg::COORD_W-1:0]  end_x,
	input  wire logic signed [glsc_pkg::COORD_W-1:0]  end_y,
	output logic                                      out_valid,
	input  wire logic                                 out_ready,
	output logic                                      segment_free
);

	localparam logic [2:0] S_CLEAR  = 3'd0;
	localparam logic [2:0] S_IDLE   = 3'd1;
	localparam logic [2:0] S_WRD    = 3'd2;
	localparam logic [2:0] S_WMOD   = 3'd3;
	localparam logic [2:0] S_CSET   = 3'd4;
	localparam logic [2:0] S_CWALK  = 3'd5;
	localparam logic [2:0] S_CDRAIN = 3'd6;
	localparam logic [2:0] S_FIN    = 3'd7;

	localparam int ROW_W = glsc_pkg::GRID_X;

	logic [2:0] state_q;
	logic [glsc_pkg::CELL_W-1:0] clr_q;
	logic [glsc_pkg::SIZE_W-1:0] grid_w_q, grid_h_q, w_sat, h_sat;
	logic act_q, occ_q;
	logic [glsc_pkg::CELL_W-1:0] wx_q, wy_q;
	logic signed [glsc_pkg::COORD_W-1:0] sx_q, sy_q, ex_q, ey_q;
	logic busy_q, res_q, chk_s1, out_valid_q, seg_free_q;
	logic [glsc_pkg::CELL_W-1:0] cx_s1;

	logic [ROW_W-1:0] grid_mem [glsc_pkg::GRID_Y];
	logic [ROW_W-1:0] rdata_q, wd;
	logic rd_en, we;
	logic [glsc_pkg::CELL_W-1:0] rd_addr, wa;

	logic [glsc_pkg::COORD_W-1:0] w_lim, h_lim;
	logic seg_inside, hit, accept, post_res;

	glsc_pkg::walk_ctl_t walk_ctl;
	glsc_pkg::walk_sts_t walk_sts;

	function automatic logic coord_in(logic signed [glsc_pkg::COORD_W-1:0] raw,
	                                  logic [glsc_pkg::COORD_W-1:0] lim);
		return !raw[glsc_pkg::COORD_W-1] &&
		       ({1'b0, raw[glsc_pkg::COORD_W-2:0]} < lim);
	endfunction

	glsc_walk u_walk (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (walk_ctl),
		.ax     (sx_q[glsc_pkg::COORD_W-2:glsc_pkg::FRAC_W]),
		.ay     (sy_q[glsc_pkg::COORD_W-2:glsc_pkg::FRAC_W]),
		.bx     (ex_q[glsc_pkg::COORD_W-2:glsc_pkg::FRAC_W]),
		.by     (ey_q[glsc_pkg::COORD_W-2:glsc_pkg::FRAC_W]),
		.sts    (walk_sts)
	);

	assign in_ready = (state_q == S_IDLE);
	assign accept = in_valid && in_ready;
	assign out_valid = out_valid_q;
	assign segment_free = seg_free_q;

	always_comb begin
		w_sat = (grid_w_q > glsc_pkg::SIZE_MAX) ? glsc_pkg::SIZE_MAX : grid_w_q;
		h_sat = (grid_h_q > glsc_pkg::SIZE_MAX) ? glsc_pkg::SIZE_MAX : grid_h_q;
		w_lim = {w_sat, {glsc_pkg::FRAC_W{1'b0}}};
		h_lim = {h_sat, {glsc_pkg::FRAC_W{1'b0}}};
		seg_inside = coord_in(sx_q, w_lim) && coord_in(ex_q, w_lim) &&
		             coord_in(sy_q, h_lim) && coord_in(ey_q, h_lim);
		hit = chk_s1 && rdata_q[cx_s1];
		walk_ctl.load = (state_q == S_CSET);
		walk_ctl.adv = (state_q == S_CWALK);
		post_res = (state_q == S_FIN) && (!out_valid_q || out_ready);
	end

	always_comb begin
		rd_en = 1'b0;
		rd_addr = walk_sts.y;
		we = 1'b0;
		wa = wy_q;
		wd = rdata_q;
		wd[wx_q] = occ_q;
		case (state_q)
			S_CLEAR: begin
				we = 1'b1;
				wa = clr_q;
				wd = '0;
			end
			S_WRD: begin
				rd_en = 1'b1;
				rd_addr = wy_q;
			end
			S_WMOD: begin
				we = 1'b1;
			end
			S_CWALK: begin
				rd_en = 1'b1;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rdata_q <= grid_mem[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			grid_mem[wa] <= wd;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			act_q <= action;
			wx_q <= cell_x;
			wy_q <= cell_y;
			occ_q <= cell_occupied;
			sx_q <= start_x;
			sy_q <= start_y;
			ex_q <= end_x;
			ey_q <= end_y;
		end
		cx_s1 <= walk_sts.x;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_w_q <= glsc_pkg::SIZE_MAX;
			grid_h_q <= glsc_pkg::SIZE_MAX;
		end else if (cfg_we) begin
			case (cfg_index)
				glsc_pkg::REG_GRID_WIDTH: grid_w_q <= cfg_data;
				glsc_pkg::REG_GRID_HEIGHT: grid_h_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			clr_q <= '0;
			busy_q <= 1'b0;
			res_q <= 1'b0;
			chk_s1 <= 1'b0;
			out_valid_q <= 1'b0;
			seg_free_q <= 1'b0;
		end else begin
			chk_s1 <= (state_q == S_CWALK);
			if (post_res) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == glsc_pkg::CELL_W'(glsc_pkg::GRID_Y - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (accept) begin
						state_q <= (action == glsc_pkg::ACT_WRITE) ? S_WRD : S_CSET;
					end
				end
				S_WRD: begin
					state_q <= S_WMOD;
				end
				S_WMOD: begin
					res_q <= 1'b0;
					state_q <= S_FIN;
				end
				S_CSET: begin
					busy_q <= 1'b0;
					if (seg_inside && act_q == glsc_pkg::ACT_CHECK) begin
						state_q <= S_CWALK;
					end else begin
						res_q <= 1'b0;
						state_q <= S_FIN;
					end
				end
				S_CWALK: begin
					busy_q <= busy_q || hit;
					if (walk_sts.last) begin
						state_q <= S_CDRAIN;
					end
				end
				S_CDRAIN: begin
					res_q <= !(busy_q || hit);
					state_q <= S_FIN;
				end
				S_FIN: begin
					if (post_res) begin
						seg_free_q <= res_q;
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

// ===== hdl/glsc_checker.sv =====
// Port-level checker for the grid line segment collision check unit, and its bind.
// Watches only the top level's ports. Depends on glsc_pkg.
`default_nettype none

module glsc_checker (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 in_valid,
	input  wire logic                                 in_ready,
	input  wire logic                                 action,
	input  wire logic                                 out_valid,
	input  wire logic                                 out_ready,
	input  wire logic                                 segment_free
);

	// A result beat that is not taken stays with the same value.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(segment_free))
		else $error("result beat dropped or changed while stalled");

	// Items are processed one at a time, so an accepted beat closes the input.
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input accepted again while an item is in progress");

	// A result is posted only at the end of work, when the input was closed.
	a_post_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> !$past(in_ready))
		else $error("result appeared without an item in progress");

	// No result appears in the cycle right after a write beat is accepted.
	a_write_latency: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && action == glsc_pkg::ACT_WRITE |=> !$rose(out_valid))
		else $error("write item result posted too early");

endmodule

bind grid_line_segment_collision_check_unit glsc_checker u_glsc_checker (.*);

`default_nettype wire
